// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL files; cds_seq.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge and ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent implication check sampled on the rising clock edge.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/cds_pkg.sv =====
package cds_pkg;

   localparam int COUNT_BITS = 16;
   localparam int OP_W       = 3;
   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_W     = 14;
   localparam int RES_W      = 9;
   localparam int UNIT_W     = 10;
   localparam int SUB_W      = COUNT_BITS + UNIT_W;
   localparam int REM_W      = COUNT_BITS + 3;

   localparam logic [YEAR_W-1:0]  YEAR_MAX       = 14'd9999;
   localparam logic [YEAR_W-1:0]  LEAP_PERIOD    = 14'd400;
   localparam logic [REM_W-1:0]   WEEK_DAYS      = REM_W'(7);
   localparam logic [UNIT_W-1:0]  UNIT_YEAR      = 10'd1;
   localparam logic [UNIT_W-1:0]  UNIT_DECADE    = 10'd10;
   localparam logic [UNIT_W-1:0]  UNIT_CENTURY   = 10'd100;
   localparam logic [UNIT_W-1:0]  UNIT_MILLENNIUM = 10'd1000;

   typedef enum logic [OP_W-1:0] {
      OP_DAY, OP_WEEK, OP_MONTH, OP_YEAR, OP_DECADE, OP_CENTURY, OP_MILLENNIUM, OP_NONE
   } op_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   typedef struct packed {
      op_type                op;
      logic [COUNT_BITS-1:0] count;
      date_type              date;
   } req_type;

   typedef struct packed {
      date_type date;
      logic     underflow;
   } rsp_type;

   // The argument is the year modulo 400.
   function automatic logic is_leap(input logic [RES_W-1:0] res);
      is_leap = (res[1:0] == 2'b00) && (res != 9'd100) && (res != 9'd200) && (res != 9'd300);
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      case (month)
         4'd2: begin
            month_days = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            month_days = 5'd30;
         end
         default: begin
            month_days = 5'd31;
         end
      endcase
   endfunction

endpackage

// ===== hdl/cds_day_step.sv =====
module cds_day_step (
   input  cds_pkg::date_type          cur,
   input  logic [cds_pkg::RES_W-1:0]  res,
   output cds_pkg::date_type          nxt,
   output logic [cds_pkg::RES_W-1:0]  res_nxt,
   output logic                       underflow
);

   logic [cds_pkg::MONTH_W-1:0] prev_month;

   assign prev_month = cur.month - cds_pkg::MONTH_W'(1);

   always_comb begin
      nxt       = cur;
      res_nxt   = res;
      underflow = 1'b0;
      if (cur.day > cds_pkg::DAY_W'(1)) begin
         nxt.day = cur.day - cds_pkg::DAY_W'(1);
      end else if (cur.month > cds_pkg::MONTH_W'(1)) begin
         nxt.month = prev_month;
         nxt.day   = cds_pkg::month_days(prev_month, cds_pkg::is_leap(res));
      end else if (cur.year <= cds_pkg::YEAR_W'(1)) begin
         underflow = 1'b1;
      end else begin
         nxt.year  = cur.year - cds_pkg::YEAR_W'(1);
         nxt.month = cds_pkg::MONTH_W'(12);
         nxt.day   = cds_pkg::DAY_W'(31);
         res_nxt   = (res == '0) ? cds_pkg::RES_W'(399) : res - cds_pkg::RES_W'(1);
      end
   end

endmodule

// ===== hdl/cds_seq.sv =====
`include "assert_macros.svh"

module cds_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  cds_pkg::req_type  req,
   output logic              req_ready,
   output logic              done_valid,
   input  logic              out_free,
   output cds_pkg::rsp_type  result
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_REDUCE, ST_CLAMP, ST_YEAR_MUL, ST_YEAR_CMP, ST_MONTH_LOAD, ST_DAYS, ST_DONE
   } state_type;

   state_type                          state_ff, state_in;
   cds_pkg::op_type                    op_ff, op_in;
   logic [cds_pkg::COUNT_BITS-1:0]     cnt_ff, cnt_in;
   cds_pkg::date_type                  date_ff, date_in;
   logic [cds_pkg::YEAR_W-1:0]         res_ff, res_in;
   logic [cds_pkg::REM_W-1:0]          rem_ff, rem_in;
   logic [cds_pkg::SUB_W-1:0]          sub_ff, sub_in;
   logic                               uf_ff, uf_in;

   cds_pkg::date_type                  step_date;
   logic [cds_pkg::RES_W-1:0]          step_res;
   logic                               step_uf;
   logic [cds_pkg::DAY_W-1:0]          cur_len;
   logic [cds_pkg::UNIT_W-1:0]         unit;

   cds_day_step u_day_step (
      .cur       (date_ff),
      .res       (res_ff[cds_pkg::RES_W-1:0]),
      .nxt       (step_date),
      .res_nxt   (step_res),
      .underflow (step_uf)
   );

   assign cur_len = cds_pkg::month_days(date_ff.month,
                                        cds_pkg::is_leap(res_ff[cds_pkg::RES_W-1:0]));

   always_comb begin
      case (op_ff)
         cds_pkg::OP_DECADE: begin
            unit = cds_pkg::UNIT_DECADE;
         end
         cds_pkg::OP_CENTURY: begin
            unit = cds_pkg::UNIT_CENTURY;
         end
         cds_pkg::OP_MILLENNIUM: begin
            unit = cds_pkg::UNIT_MILLENNIUM;
         end
         default: begin
            unit = cds_pkg::UNIT_YEAR;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      date_in  = date_ff;
      res_in   = res_ff;
      rem_in   = rem_ff;
      sub_in   = sub_ff;
      uf_in    = uf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req.op;
               cnt_in   = req.count;
               uf_in    = 1'b0;
               date_in.day = req.date.day;
               if (req.date.month == '0) begin
                  date_in.month = cds_pkg::MONTH_W'(1);
               end else if (req.date.month > cds_pkg::MONTH_W'(12)) begin
                  date_in.month = cds_pkg::MONTH_W'(12);
               end else begin
                  date_in.month = req.date.month;
               end
               if (req.date.year > cds_pkg::YEAR_MAX) begin
                  date_in.year = cds_pkg::YEAR_MAX;
               end else begin
                  date_in.year = req.date.year;
               end
               res_in = date_in.year;
               if (req.date.year == '0) begin
                  uf_in    = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (res_ff >= cds_pkg::LEAP_PERIOD) begin
               res_in = res_ff - cds_pkg::LEAP_PERIOD;
            end else begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (date_ff.day == '0) begin
               date_in.day = cds_pkg::DAY_W'(1);
            end else if (date_ff.day > cur_len) begin
               date_in.day = cur_len;
            end
            case (op_ff)
               cds_pkg::OP_DAY: begin
                  rem_in   = cds_pkg::REM_W'(cnt_ff);
                  state_in = ST_DAYS;
               end
               cds_pkg::OP_WEEK: begin
                  rem_in   = cds_pkg::REM_W'(cnt_ff) * cds_pkg::WEEK_DAYS;
                  state_in = ST_DAYS;
               end
               cds_pkg::OP_MONTH: begin
                  state_in = ST_MONTH_LOAD;
               end
               cds_pkg::OP_NONE: begin
                  state_in = ST_DONE;
               end
               default: begin
                  state_in = ST_YEAR_MUL;
               end
            endcase
         end
         ST_YEAR_MUL: begin
            sub_in   = cds_pkg::SUB_W'(cnt_ff) * cds_pkg::SUB_W'(unit);
            state_in = ST_YEAR_CMP;
         end
         ST_YEAR_CMP: begin
            if (sub_ff >= cds_pkg::SUB_W'(date_ff.year)) begin
               uf_in = 1'b1;
            end else begin
               date_in.year = date_ff.year - cds_pkg::YEAR_W'(sub_ff);
            end
            state_in = ST_DONE;
         end
         ST_MONTH_LOAD: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff - cds_pkg::COUNT_BITS'(1);
               rem_in   = cds_pkg::REM_W'(cur_len);
               state_in = ST_DAYS;
            end
         end
         ST_DAYS: begin
            if (rem_ff == '0) begin
               state_in = (op_ff == cds_pkg::OP_MONTH) ? ST_MONTH_LOAD : ST_DONE;
            end else if (step_uf) begin
               uf_in    = 1'b1;
               state_in = ST_DONE;
            end else begin
               date_in  = step_date;
               res_in   = cds_pkg::YEAR_W'(step_res);
               rem_in   = rem_ff - cds_pkg::REM_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      date_ff <= date_in;
      res_ff  <= res_in;
      rem_ff  <= rem_in;
      sub_ff  <= sub_in;
      uf_ff   <= uf_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);

   always_comb begin
      result.underflow = uf_ff;
      if (uf_ff) begin
         result.date = '0;
      end else begin
         result.date = date_ff;
      end
   end

   `ASSERT_IMPL(a_res_reduced, clock, reset, state_ff == ST_DAYS, res_ff < cds_pkg::LEAP_PERIOD, "year residue not reduced below 400 while stepping days")
   `ASSERT_IMPL(a_date_valid, clock, reset, state_ff == ST_DAYS, date_ff.day != '0 && date_ff.month != '0 && date_ff.month <= cds_pkg::MONTH_W'(12) && date_ff.year != '0, "invalid date while stepping days")
   `ASSERT_CLK(a_rem_count, clock, reset, (state_ff == ST_DAYS && rem_ff != '0 && !step_uf) |=> (rem_ff == $past(rem_ff) - cds_pkg::REM_W'(1)), "day counter did not count down by one")

endmodule

// ===== hdl/calendar_date_subtract_top.sv =====
// Gregorian date decrement. A request carries a valid date, a unit (day, week, month, year,
// decade, century or millennium) and a count, and the response is the date moved back by that
// many units, or 0.0.0 with the underflow flag when it would fall before 1.1.1. Requests are
// handled one at a time by a sequencer around a single one-day-back step unit, so the request
// channel is not ready while a request is in work. Each request first reduces the year modulo
// 400 for the leap rule by repeated subtraction, then takes one day step per cycle: count steps
// for days, 7 x count for weeks and the current month's length per month for months (each month
// also has a load state and a final check), while the year-based units use a multiply and a compare.
// A response register lets the next request enter while the previous response still waits.
module calendar_date_subtract_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // step_count[15:0], in_day[20:16], in_month[24:21], in_year[38:25]
   input  logic [2:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_day[4:0], out_month[8:5], out_year[22:9]
   output logic        rsp_tuser   // underflow
);

   cds_pkg::req_type req;
   cds_pkg::rsp_type result;
   cds_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;
   logic             done_valid;
   logic             out_free;
   logic             seq_ready;

   assign req.op         = cds_pkg::op_type'(req_tuser);
   assign req.count      = req_tdata[15:0];
   assign req.date.day   = req_tdata[20:16];
   assign req.date.month = req_tdata[24:21];
   assign req.date.year  = req_tdata[38:25];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = seq_ready;

   cds_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req        (req),
      .req_ready  (seq_ready),
      .done_valid (done_valid),
      .out_free   (out_free),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= done_valid;
      end
      if (out_free && done_valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.date.year, rsp_ff.date.month, rsp_ff.date.day};
   assign rsp_tuser  = rsp_ff.underflow;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 5_000_000;

   class date_scoreboard;
      cds_pkg::rsp_type expected_q[$];
      int      errors;
      int      reported;
      int      walk_day;
      int      walk_month;
      int      walk_year;

      static function int month_length(int year, int month);
         if (month == 2) begin
            if ((year % 4 == 0 && year % 100 != 0) || year % 400 == 0) begin
               return 29;
            end
            return 28;
         end
         if (month == 4 || month == 6 || month == 9 || month == 11) begin
            return 30;
         end
         return 31;
      endfunction

      // Walks the current date back one day at a time and stops at the first underflow.
      function bit walk_back(longint days);
         longint i;
         for (i = 0; i < days; i++) begin
            if (walk_day > 1) begin
               walk_day--;
            end else if (walk_month > 1) begin
               walk_month--;
               walk_day = month_length(walk_year, walk_month);
            end else if (walk_year <= 1) begin
               return 1'b0;
            end else begin
               walk_year--;
               walk_month = 12;
               walk_day = 31;
            end
         end
         return 1'b1;
      endfunction

      function void note_request(cds_pkg::op_type op, bit [15:0] count, bit [4:0] day,
                                 bit [3:0] month, bit [13:0] year);
         cds_pkg::rsp_type want;
         bit      ok;
         longint  unit;
         longint  span;
         int      limit;
         int      k;
         walk_month = int'(month);
         if (walk_month < 1) begin
            walk_month = 1;
         end
         if (walk_month > 12) begin
            walk_month = 12;
         end
         walk_year = int'(year);
         if (walk_year > 9999) begin
            walk_year = 9999;
         end
         walk_day = int'(day);
         if (walk_day < 1) begin
            walk_day = 1;
         end
         limit = month_length(walk_year == 0 ? 1 : walk_year, walk_month);
         if (walk_day > limit) begin
            walk_day = limit;
         end
         ok = 1'b1;
         if (walk_year == 0) begin
            ok = 1'b0;
         end else begin
            case (op)
               cds_pkg::OP_DAY: begin
                  ok = walk_back(longint'(count));
               end
               cds_pkg::OP_WEEK: begin
                  ok = walk_back(longint'(count) * 7);
               end
               cds_pkg::OP_MONTH: begin
                  for (k = 0; k < int'(count) && ok; k++) begin
                     ok = walk_back(longint'(month_length(walk_year, walk_month)));
                  end
               end
               cds_pkg::OP_YEAR, cds_pkg::OP_DECADE, cds_pkg::OP_CENTURY,
               cds_pkg::OP_MILLENNIUM: begin
                  unit = (op == cds_pkg::OP_YEAR) ? longint'(cds_pkg::UNIT_YEAR)
                       : (op == cds_pkg::OP_DECADE) ? longint'(cds_pkg::UNIT_DECADE)
                       : (op == cds_pkg::OP_CENTURY) ? longint'(cds_pkg::UNIT_CENTURY)
                       : longint'(cds_pkg::UNIT_MILLENNIUM);
                  span = longint'(count) * unit;
                  if (span >= longint'(walk_year)) begin
                     ok = 1'b0;
                  end else begin
                     walk_year = walk_year - int'(span);
                  end
               end
               default: begin
               end
            endcase
         end
         want.date.day   = ok ? 5'(walk_day) : 5'd0;
         want.date.month = ok ? 4'(walk_month) : 4'd0;
         want.date.year  = ok ? 14'(walk_year) : 14'd0;
         want.underflow  = !ok;
         expected_q.push_back(want);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("mismatch in %s: expected %0d, got %0d", name, want, got);
            end
         end
      endfunction

      function void check_response(bit [4:0] day, bit [3:0] month, bit [13:0] year,
                                   bit underflow);
         cds_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("response %0d.%0d.%0d underflow %0d arrived with no request pending",
                        day, month, year, underflow);
            end
            return;
         end
         want = expected_q.pop_front();
         compare_field("day", int'(want.date.day), int'(day));
         compare_field("month", int'(want.date.month), int'(month));
         compare_field("year", int'(want.date.year), int'(year));
         compare_field("underflow", int'(want.underflow), int'(underflow));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;

   logic           steady = 1'b0;
   int             cycles = 0;
   date_scoreboard board;

   calendar_date_subtract_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         board.note_request(cds_pkg::op_type'(req_tuser), req_tdata[15:0], req_tdata[20:16],
                            req_tdata[24:21], req_tdata[38:25]);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_response(rsp_tdata[4:0], rsp_tdata[8:5], rsp_tdata[22:9], rsp_tuser);
         end
         rsp_tready <= steady || ($urandom_range(0, 99) >= 33);
      end
   end

   task automatic send_request(cds_pkg::op_type op, bit [15:0] count, bit [4:0] day,
                               bit [3:0] month, bit [13:0] year);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, year, month, day, count};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin : stimulus
      cds_pkg::op_type op;
      bit [15:0] count;
      bit [4:0]  day;
      bit [3:0]  month;
      bit [13:0] year;
      int        divisor;
      int        n;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_request(cds_pkg::OP_DAY, 16'd0, 5'd15, 4'd6, 14'd2000);
      send_request(cds_pkg::OP_DAY, 16'd1, 5'd1, 4'd1, 14'd1);
      send_request(cds_pkg::OP_DAY, 16'd1, 5'd1, 4'd3, 14'd2000);
      send_request(cds_pkg::OP_DAY, 16'd1, 5'd1, 4'd3, 14'd1900);
      send_request(cds_pkg::OP_DAY, 16'd1, 5'd1, 4'd3, 14'd2024);
      send_request(cds_pkg::OP_DAY, 16'd1, 5'd1, 4'd1, 14'd2000);
      send_request(cds_pkg::OP_DAY, 16'd65535, 5'd31, 4'd12, 14'd9999);
      send_request(cds_pkg::OP_WEEK, 16'd1, 5'd3, 4'd1, 14'd2001);
      send_request(cds_pkg::OP_WEEK, 16'd65535, 5'd7, 4'd7, 14'd5);
      send_request(cds_pkg::OP_MONTH, 16'd1, 5'd31, 4'd3, 14'd2023);
      send_request(cds_pkg::OP_MONTH, 16'd12, 5'd15, 4'd8, 14'd9999);
      send_request(cds_pkg::OP_MONTH, 16'd65535, 5'd10, 4'd10, 14'd3);
      send_request(cds_pkg::OP_YEAR, 16'd1, 5'd29, 4'd2, 14'd2024);
      send_request(cds_pkg::OP_YEAR, 16'd9998, 5'd1, 4'd1, 14'd9999);
      send_request(cds_pkg::OP_YEAR, 16'd9999, 5'd1, 4'd1, 14'd9999);
      send_request(cds_pkg::OP_DECADE, 16'd5, 5'd5, 4'd5, 14'd1990);
      send_request(cds_pkg::OP_CENTURY, 16'd65535, 5'd1, 4'd1, 14'd9999);
      send_request(cds_pkg::OP_MILLENNIUM, 16'd9, 5'd31, 4'd12, 14'd9999);
      send_request(cds_pkg::OP_NONE, 16'd1234, 5'd30, 4'd6, 14'd2000);
      send_request(cds_pkg::OP_DAY, 16'd3, 5'd0, 4'd0, 14'd2000);
      send_request(cds_pkg::OP_DAY, 16'd2, 5'd31, 4'd2, 14'd2001);
      send_request(cds_pkg::OP_DAY, 16'd1, 5'd31, 4'd15, 14'd16383);
      send_request(cds_pkg::OP_MONTH, 16'd3, 5'd12, 4'd6, 14'd0);
      send_request(cds_pkg::OP_DECADE, 16'd1, 5'd0, 4'd13, 14'd10000);

      for (n = 0; n < 580; n++) begin
         steady = (n >= 250 && n < 350);
         if ($urandom_range(0, 99) < 2) begin
            op = cds_pkg::OP_NONE;
         end else begin
            op = cds_pkg::op_type'($urandom_range(0, 6));
         end
         if ($urandom_range(0, 99) < 15) begin
            year = 14'($urandom_range(1, 40));
         end else begin
            year = 14'($urandom_range(1, 9999));
         end
         month = 4'($urandom_range(1, 12));
         day = 5'($urandom_range(1, date_scoreboard::month_length(int'(year), int'(month))));
         if ($urandom_range(0, 19) == 0) begin
            year = 14'(4 * $urandom_range(1, 2499));
            month = 4'd2;
            day = 5'd29;
         end
         case (op)
            cds_pkg::OP_DAY: begin
               if ($urandom_range(0, 9) == 0) begin
                  count = 16'($urandom_range(0, 1500));
               end else begin
                  count = 16'($urandom_range(0, 100));
               end
            end
            cds_pkg::OP_WEEK: begin
               count = 16'($urandom_range(0, 60));
            end
            cds_pkg::OP_MONTH: begin
               count = 16'($urandom_range(0, 24));
            end
            default: begin
               divisor = (op == cds_pkg::OP_DECADE) ? 10 : (op == cds_pkg::OP_CENTURY) ? 100
                       : (op == cds_pkg::OP_MILLENNIUM) ? 1000 : 1;
               if ($urandom_range(0, 3) == 0) begin
                  count = 16'($urandom());
               end else begin
                  count = 16'($urandom_range(0, int'(year) / divisor + 1));
               end
            end
         endcase
         if ($urandom_range(0, 24) == 0) begin
            day = 5'($urandom_range(0, 31));
            month = 4'($urandom_range(0, 15));
            year = ($urandom_range(0, 1) == 0) ? 14'd0 : 14'($urandom_range(10000, 16383));
         end
         send_request(op, count, day, month, year);
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (board.expected_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (64) @(posedge clock);
      if (board.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cds_pkg.sv
hdl/cds_day_step.sv
hdl/cds_seq.sv
hdl/calendar_date_subtract_top.sv
bench/testbench.sv
